// ===== hw/rtl/mccfp_pkg.sv =====
// Shared types, constants and helpers for the motor CAN command frame packer.
// No dependencies.
package mccfp_pkg;

  localparam logic signed [15:0] VOLT_LIMIT = 16'sd25000;
  localparam logic signed [15:0] CURR_LIMIT = 16'sd16384;
  localparam logic [10:0] ID_LOW  = 11'h200;
  localparam logic [10:0] ID_MID  = 11'h1FF;
  localparam logic [10:0] ID_HIGH = 11'h2FF;

  typedef enum logic [1:0] {
    GRP_LOW,
    GRP_MID,
    GRP_HIGH
  } grp_t;

  typedef logic [3:0][15:0] frame_t;

  typedef struct packed {
    logic        wr;
    logic        emit;
    grp_t        grp;
    logic [1:0]  slot;
    logic [15:0] value;
  } lane_op_t;

  function automatic logic [10:0] id_of(grp_t g);
    logic [10:0] id;
    unique case (g)
      GRP_LOW:  id = ID_LOW;
      GRP_MID:  id = ID_MID;
      GRP_HIGH: id = ID_HIGH;
      default:  id = ID_MID;
    endcase
    return id;
  endfunction

endpackage

// ===== hw/rtl/mccfp_lane.sv =====
// One command lane: clamps a motor value and maps the motor number to a group and slot.
// Depends on mccfp_pkg.
module mccfp_lane (
  input  logic               en,
  input  logic               volt,
  input  logic               emit_en,
  input  logic [3:0]         motor,
  input  logic signed [15:0] value,
  output mccfp_pkg::lane_op_t op
);
  import mccfp_pkg::*;

  logic signed [15:0] lim;
  logic signed [15:0] clamped;
  logic               hit;
  grp_t               grp;

  always_comb begin
    lim = volt ? VOLT_LIMIT : CURR_LIMIT;
    if (value >= lim) begin
      clamped = lim;
    end else if (value <= -lim) begin
      clamped = -lim;
    end else begin
      clamped = value;
    end

    hit = 1'b0;
    grp = GRP_MID;
    if (motor >= 4'd1 && motor <= 4'd4) begin
      hit = 1'b1;
      grp = volt ? GRP_MID : GRP_LOW;
    end else if (motor >= 4'd5 && motor <= 4'd7) begin
      hit = 1'b1;
      grp = volt ? GRP_HIGH : GRP_MID;
    end else if (motor == 4'd8 && !volt) begin
      hit = 1'b1;
      grp = GRP_MID;
    end

    op.wr    = en && hit;
    op.emit  = en && hit && emit_en;
    op.grp   = grp;
    op.slot  = motor[1:0] - 2'd1;
    op.value = clamped;
  end

endmodule

// ===== hw/rtl/mccfp_merge.sv =====
// Merge stage: holds the three group frames, applies the two lane ops in order
// and emits frames through an output register. Depends on mccfp_pkg.
module mccfp_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mccfp_pkg::lane_op_t op0,
  input  mccfp_pkg::lane_op_t op1,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [10:0]         frame_id,
  output logic [15:0]         slot_word_0,
  output logic [15:0]         slot_word_1,
  output logic [15:0]         slot_word_2,
  output logic [15:0]         slot_word_3,
  output logic                last_frame
);
  import mccfp_pkg::*;

  lane_op_t [1:0] job;
  logic           job_valid;
  logic           step;
  frame_t         frame_low;
  frame_t         frame_mid;
  frame_t         frame_high;

  lane_op_t op;
  frame_t   cur;
  frame_t   upd;
  logic     advance;
  logic     push;
  logic     accept;

  always_comb begin
    op = job[step];
    unique case (op.grp)
      GRP_LOW:  cur = frame_low;
      GRP_MID:  cur = frame_mid;
      GRP_HIGH: cur = frame_high;
      default:  cur = frame_mid;
    endcase
    upd = cur;
    upd[op.slot] = op.value;
    advance  = job_valid && (!op.emit || !out_valid || out_ready);
    push     = advance && op.emit;
    in_ready = !job_valid || (step && advance);
    accept   = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid  <= 1'b0;
      step       <= 1'b0;
      out_valid  <= 1'b0;
      frame_low  <= '0;
      frame_mid  <= '0;
      frame_high <= '0;
    end else begin
      if (accept) begin
        job       <= {op1, op0};
        job_valid <= 1'b1;
        step      <= 1'b0;
      end else if (advance) begin
        if (step) begin
          job_valid <= 1'b0;
        end else begin
          step <= 1'b1;
        end
      end

      if (advance && op.wr) begin
        unique case (op.grp)
          GRP_LOW:  frame_low  <= upd;
          GRP_MID:  frame_mid  <= upd;
          GRP_HIGH: frame_high <= upd;
          default:  frame_mid  <= upd;
        endcase
      end

      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      frame_id    <= id_of(op.grp);
      slot_word_0 <= upd[0];
      slot_word_1 <= upd[1];
      slot_word_2 <= upd[2];
      slot_word_3 <= upd[3];
      last_frame  <= step || !job[1].emit;
    end
  end

  a_idle_no_push: assert property (@(posedge clk) disable iff (rst)
    !job_valid |-> !push) else $error("push without job");
  a_accept_step0: assert property (@(posedge clk) disable iff (rst)
    accept |=> job_valid && !step) else $error("job not loaded at step 0");
  a_job_done: assert property (@(posedge clk) disable iff (rst)
    job_valid && step && advance && !accept |=> !job_valid) else $error("job not retired");
  a_push_valid: assert property (@(posedge clk) disable iff (rst)
    push |=> out_valid) else $error("pushed word lost");

endmodule

// ===== hw/rtl/motor_can_command_frame_packer.sv =====
// Motor CAN command frame packer: an accepted command word is decoded by two lanes
// (one per motor) and applied to the stored group frames in the merge stage, which
// applies the two lane ops in turn and can take the next command word while the second
// is applied; each emitted frame (0, 1 or 2 per command) leaves through an output
// register, one word per cycle while out_ready is high. motor_type resets to current type.
// Depends on mccfp_pkg, mccfp_lane and mccfp_merge.
module motor_can_command_frame_packer (
  input  logic               clk,
  input  logic               rst,
  input  logic               motor_type_we,
  input  logic               motor_type_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic [3:0]         first_motor,
  input  logic signed [15:0] first_value,
  input  logic [3:0]         second_motor,
  input  logic signed [15:0] second_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [10:0]        frame_id,
  output logic [15:0]        slot_word_0,
  output logic [15:0]        slot_word_1,
  output logic [15:0]        slot_word_2,
  output logic [15:0]        slot_word_3,
  output logic               last_frame
);
  import mccfp_pkg::*;

  logic     motor_type;
  logic     pair_same;
  logic     volt;
  lane_op_t op0;
  lane_op_t op1;

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_type <= 1'b1;
    end else if (motor_type_we) begin
      motor_type <= motor_type_wdata;
    end
  end

  // two-motor pair with both motors in 1-4 or both in 5-7 always uses voltage mapping and emits once
  always_comb begin
    pair_same = command &&
      ((first_motor >= 4'd1 && first_motor <= 4'd4 &&
        second_motor >= 4'd1 && second_motor <= 4'd4) ||
       (first_motor >= 4'd5 && first_motor <= 4'd7 &&
        second_motor >= 4'd5 && second_motor <= 4'd7));
    volt = pair_same || !motor_type;
  end

  mccfp_lane u_lane0 (
    .en      (1'b1),
    .volt    (volt),
    .emit_en (!pair_same),
    .motor   (first_motor),
    .value   (first_value),
    .op      (op0)
  );

  mccfp_lane u_lane1 (
    .en      (command),
    .volt    (volt),
    .emit_en (1'b1),
    .motor   (second_motor),
    .value   (second_value),
    .op      (op1)
  );

  mccfp_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op0         (op0),
    .op1         (op1),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .frame_id    (frame_id),
    .slot_word_0 (slot_word_0),
    .slot_word_1 (slot_word_1),
    .slot_word_2 (slot_word_2),
    .slot_word_3 (slot_word_3),
    .last_frame  (last_frame)
  );

endmodule
